// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RTL, included by learning_switch_forward_table_core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of i_clk, ignored while i_rst_n is low.
`define LSFT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Property checked at every rising edge of i_clk, also during reset.
`define LSFT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/lsft_pkg.sv
// ----------------------------------------------------------------------------
// lsft_pkg
// Types, sizes and helper functions of the learning switch forwarding table.
// ----------------------------------------------------------------------------
package lsft_pkg;

    localparam int TABLE_ENTRIES = 128;
    localparam int PORT_COUNT    = 8;

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int ADDR_W  = 8;
    localparam int PORT_W  = 3;
    localparam int MASK_W  = 8;
    localparam int CFG_W   = 4;
    localparam int ENTRY_W = ADDR_W + PORT_W;

    localparam logic [CFG_W-1:0] ACTIVE_PORTS_RESET = CFG_W'(8);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Flood to every active port except the arrival port. The active count
    // saturates at the number of ports the switch has.
    function automatic logic [MASK_W-1:0] flood_mask(input logic [CFG_W-1:0] act,
                                                     input logic [PORT_W-1:0] port);
        logic [MASK_W-1:0] m;
        int                n;
        n = (int'(act) > PORT_COUNT) ? PORT_COUNT : int'(act);
        for (int k = 0; k < MASK_W; k++) begin
            m[k] = (k < n) && (k != int'(port));
        end
        return m;
    endfunction

endpackage

// File: hw/rtl/learning_switch_forward_table_core.sv
// ----------------------------------------------------------------------------
// learning_switch_forward_table_core
// A word is taken when start is high and busy is low. A miss reads every valid entry before
// o_valid strobes; a hit stops further reads once it has been recorded. The result flags and
// the port mask are registered from the finishing state.
// The next word is taken at the edge that ends the strobe cycle; the receiver cannot stall.
// Reset (synchronous, active low) empties the table and sets the active port count to 8.
// ----------------------------------------------------------------------------
module learning_switch_forward_table_core
    import lsft_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration: active port count.
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    // Command side.
    input  logic              start,
    output logic              busy,
    input  logic [ADDR_W-1:0] i_src_addr,
    input  logic [ADDR_W-1:0] i_dst_addr,
    input  logic [PORT_W-1:0] i_in_port,
    // Result side, a one-cycle o_valid strobe per word.
    output logic              o_valid,
    output logic [MASK_W-1:0] o_port_mask,
    output logic              o_hit,
    output logic              o_learned,
    output logic              o_table_full
);

`include "assert_macros.svh"

    // Entries are only ever added, always into the lowest free slot, so the
    // valid entries always form the prefix 0 .. fill-1. A fill count thus
    // stands in for the per-entry valid bits: entry i is valid when i < fill,
    // the first free entry is fill itself, and the table is full when fill
    // reaches TABLE_ENTRIES.

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_fill, n_fill;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_cmp, n_cmp;
    logic                r_hit, n_hit;
    logic                r_present, n_present;
    logic [PORT_W-1:0]   r_hit_port, n_hit_port;
    logic [CFG_W-1:0]    r_active_ports;

    // Latched header of the word in progress.
    logic [ADDR_W-1:0]   r_src, r_dst;
    logic [PORT_W-1:0]   r_in_port;

    // Result registers.
    logic                r_out_valid, n_out_valid;
    logic [MASK_W-1:0]   r_out_mask, n_out_mask;
    logic                r_out_hit, n_out_hit;
    logic                r_out_learned, n_out_learned;
    logic                r_out_full, n_out_full;

    // RAM access.
    logic                rd_en;
    logic                wr_en;
    logic [ENTRY_W-1:0]  rd_data;
    logic [ADDR_W-1:0]   rd_addr_f;
    logic [PORT_W-1:0]   rd_port_f;

    logic                accept;
    logic                scan_done;
    logic                tbl_full;
    logic                need_learn;

    assign accept     = start && (r_state == ST_IDLE);
    assign tbl_full   = (r_fill == CNT_W'(TABLE_ENTRIES));
    assign need_learn = !r_hit && !r_present;

    // A read is issued for each valid entry until a hit is known. The compare
    // stage works in the cycle after the read because of the RAM read register, so
    // the scan is finished once no compare is pending and either a hit is
    // recorded or the last valid entry has been read.
    assign rd_en     = (r_state == ST_SCAN) && (r_idx != r_fill) && !r_hit;
    assign scan_done = !r_cmp && (r_hit || (r_idx == r_fill));
    assign wr_en     = (r_state == ST_DONE) && need_learn && !tbl_full;

    assign rd_addr_f = rd_data[ENTRY_W-1:PORT_W];
    assign rd_port_f = rd_data[PORT_W-1:0];

    lsft_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_fill[IDX_W-1:0]),
        .i_wdata ({r_src, r_in_port}),
        .i_re    (rd_en),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rd_data)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_idx         = r_idx;
        n_cmp         = rd_en;
        n_hit         = r_hit;
        n_present     = r_present;
        n_hit_port    = r_hit_port;
        n_fill        = r_fill;
        n_out_valid   = 1'b0;
        n_out_mask    = r_out_mask;
        n_out_hit     = r_out_hit;
        n_out_learned = r_out_learned;
        n_out_full    = r_out_full;
        case (r_state)
            ST_IDLE: begin
                n_idx     = '0;
                n_hit     = 1'b0;
                n_present = 1'b0;
            end
            ST_SCAN: begin
                if (rd_en) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                if (r_cmp) begin
                    // Only the first matching entry gives the port.
                    if (!r_hit && (rd_addr_f == r_dst)) begin
                        n_hit      = 1'b1;
                        n_hit_port = rd_port_f;
                    end
                    if (rd_addr_f == r_src) begin
                        n_present = 1'b1;
                    end
                end
            end
            ST_DONE: begin
                n_out_valid   = 1'b1;
                n_out_hit     = r_hit;
                n_out_mask    = r_hit ? (MASK_W'(1) << r_hit_port)
                                      : flood_mask(r_active_ports, r_in_port);
                n_out_learned = need_learn && !tbl_full;
                n_out_full    = need_learn && tbl_full;
                if (wr_en) begin
                    n_fill = r_fill + CNT_W'(1);
                end
            end
            default: begin
                n_cmp = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_fill         <= '0;
            r_cmp          <= 1'b0;
            r_out_valid    <= 1'b0;
            r_active_ports <= ACTIVE_PORTS_RESET;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_cmp       <= n_cmp;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_active_ports <= i_cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_hit         <= n_hit;
        r_present     <= n_present;
        r_hit_port    <= n_hit_port;
        r_out_mask    <= n_out_mask;
        r_out_hit     <= n_out_hit;
        r_out_learned <= n_out_learned;
        r_out_full    <= n_out_full;
        if (accept) begin
            r_src     <= i_src_addr;
            r_dst     <= i_dst_addr;
            r_in_port <= i_in_port;
        end
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_port_mask  = r_out_mask;
    assign o_hit        = r_out_hit;
    assign o_learned    = r_out_learned;
    assign o_table_full = r_out_full;

    // The fill count never runs past the table size.
    `LSFT_ASSERT(a_fill_range, r_fill <= CNT_W'(TABLE_ENTRIES), "fill count overflow")
    // A result strobe always follows the finishing state.
    `LSFT_ASSERT(a_valid_after_done, o_valid |-> $past(r_state == ST_DONE), "stray result strobe")
    // A hit never learns and never reports a full table.
    `LSFT_ASSERT(a_hit_excl, o_valid |-> !(o_hit && (o_learned || o_table_full)), "hit flags clash")
    // Learning adds exactly one entry.
    `LSFT_ASSERT(a_learn, o_valid && o_learned |-> r_fill == $past(r_fill) + CNT_W'(1), "bad fill")
    // An accepted word starts a table scan.
    `LSFT_ASSERT(a_start_scan, (start && !busy) |=> (r_state == ST_SCAN), "scan not started")

endmodule

// File: hw/rtl/lsft_ram.sv
// ----------------------------------------------------------------------------
// lsft_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lsft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
